// ===== rtl/hbfa_pkg.sv =====
package hbfa_pkg;

    localparam int REGION_COUNT_DEF = 16384;
    localparam int FRAMES_PER_REGION = 256;
    localparam int FRAME_BYTES = 4096;
    localparam int KIND_W = 3;
    localparam int ADDR_W = 35;
    localparam int WIDX_W = 16;
    localparam int WORD_W = 64;
    localparam int CNT_W = 23;
    localparam int REGION_W = 14;
    localparam int SUM_IDX_W = 8;
    localparam int MAP_ADDR_W = 16;
    localparam int ROOT_WORDS = 4;

    typedef enum logic [KIND_W-1:0] {
        K_LOAD  = 3'd0,
        K_INIT  = 3'd1,
        K_ALLOC = 3'd2,
        K_FREE  = 3'd3,
        K_COUNT = 3'd4,
        K_HIGH  = 3'd5
    } kind_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_IN_CHK,
        ST_IN_SWEEP,
        ST_AR_LOAD,
        ST_AR_SCAN,
        ST_AS_WAIT,
        ST_AS_SCAN,
        ST_AW_WAIT,
        ST_FR_WAIT,
        ST_RF_RD,
        ST_RF_SW,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ADDR_W-1:0] address;
        logic [WIDX_W-1:0] word_index;
        logic [WORD_W-1:0] word_value;
    } req_t;

    typedef struct packed {
        logic                  we;
        logic [MAP_ADDR_W-1:0] addr;
        logic [WORD_W-1:0]     allocated;
        logic [WORD_W-1:0]     usable;
    } map_req_t;

    typedef struct packed {
        logic                 we;
        logic [SUM_IDX_W-1:0] addr;
        logic [WORD_W-1:0]    wdata;
    } sum_req_t;

    typedef struct packed {
        logic             busy;
        logic             ready;
        logic [CNT_W-1:0] free_count;
        logic [CNT_W-1:0] managed_count;
    } status_t;

    function automatic logic [5:0] low_set(input logic [WORD_W-1:0] x);
        logic [5:0] n;
        n = 6'd0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (x[i]) begin
                n = 6'(i);
            end
        end
        return n;
    endfunction

    function automatic logic [6:0] ones(input logic [WORD_W-1:0] x);
        logic [6:0] n;
        n = 7'd0;
        for (int i = 0; i < WORD_W; i++) begin
            n = n + 7'(x[i]);
        end
        return n;
    endfunction

    function automatic logic [WORD_W-1:0] mask_ge(input logic [5:0] n);
        return {WORD_W{1'b1}} << n;
    endfunction

endpackage

// ===== rtl/hierarchical_bitmap_frame_allocator_core.sv =====
// Hierarchical bitmap allocator for 4 KiB frames. Per-region usable and
// allocated words share one RAM (REGION_COUNT*4 entries); the per-region
// summary sits in a second RAM (REGION_COUNT/64 entries); root words are in
// flops. The user must keep REGION_COUNT a power of two; the block itself
// does not enforce this. After reset the block clears every bitmap RAM word
// before tready rises. Load, count, high query and beats rejected on their
// fields go from idle straight to the response. Init sweeps every bitmap
// word once, and stops with a fault at word 0 if frame 0 is marked usable.
// Alloc scans root words, then summary words, then regions and their bitmap
// words, and updates the summary when a frame is found. Free reads the
// frame's bitmap word and, if the frame exists and is allocated, rereads the
// region's words and updates the summary. The block works on one beat at a
// time; a result held in the output register does not stop the next beat
// from being taken.
module hierarchical_bitmap_frame_allocator_core #(
    parameter int REGION_COUNT = hbfa_pkg::REGION_COUNT_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [119:0] s_axis_tdata,  // address[34:0], word_index, word_value, zero pad
    input  logic [2:0]   s_axis_tuser,  // kind
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [39:0]  m_axis_tdata,  // result[34:0], zero pad
    output logic [0:0]   m_axis_tuser   // fault
);
    import hbfa_pkg::*;

    localparam int MAP_WORDS = REGION_COUNT * 4;
    localparam int MAP_AW = $clog2(MAP_WORDS);
    localparam int SUM_WORDS = REGION_COUNT / 64;
    localparam int SUM_AW = (SUM_WORDS > 1) ? $clog2(SUM_WORDS) : 1;

    req_t               req;
    logic               rsp_valid, rsp_ready, rsp_fault;
    logic [ADDR_W-1:0]  rsp_result;
    map_req_t           map_req;
    logic [2*WORD_W-1:0] map_rdata;
    sum_req_t           sum_req;
    logic [WORD_W-1:0]  sum_rdata;
    status_t            status;

    logic               out_valid_reg;
    logic [ADDR_W-1:0]  out_result_reg;
    logic               out_fault_reg;

    assign req.kind = s_axis_tuser;
    assign req.address = s_axis_tdata[34:0];
    assign req.word_index = s_axis_tdata[50:35];
    assign req.word_value = s_axis_tdata[114:51];

    assign rsp_ready = !out_valid_reg || m_axis_tready;

    hbfa_ctrl #(
        .REGION_COUNT(REGION_COUNT)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (s_axis_tvalid),
        .req       (req),
        .req_ready (s_axis_tready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_result(rsp_result),
        .rsp_fault (rsp_fault),
        .map_req   (map_req),
        .map_rdata (map_rdata),
        .sum_req   (sum_req),
        .sum_rdata (sum_rdata),
        .status    (status)
    );

    hbfa_ram #(
        .WIDTH(2 * WORD_W),
        .DEPTH(MAP_WORDS)
    ) u_map_ram (
        .clk  (clk),
        .we   (map_req.we),
        .addr (map_req.addr[MAP_AW-1:0]),
        .wdata({map_req.allocated, map_req.usable}),
        .rdata(map_rdata)
    );

    hbfa_ram #(
        .WIDTH(WORD_W),
        .DEPTH(SUM_WORDS)
    ) u_sum_ram (
        .clk  (clk),
        .we   (sum_req.we),
        .addr (sum_req.addr[SUM_AW-1:0]),
        .wdata(sum_req.wdata),
        .rdata(sum_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (rsp_valid && rsp_ready)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rsp_valid && rsp_ready)
        begin
            out_result_reg <= rsp_result;
            out_fault_reg <= rsp_fault;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = {5'b0, out_result_reg};
    assign m_axis_tuser = out_fault_reg;

    a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        status.busy |-> !s_axis_tready)
        else $error("input taken during clearing pass");

    a_fault_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == '0))
        else $error("faulting beat carries nonzero result");

    a_free_le_managed: assert property (@(posedge clk) disable iff (!rst_n)
        status.free_count <= status.managed_count)
        else $error("free count above managed count");

    a_uninit_no_count: assert property (@(posedge clk) disable iff (!rst_n)
        !status.ready |-> (status.free_count == '0))
        else $error("free count nonzero before init");

endmodule

// ===== rtl/hbfa_ram.sv =====
module hbfa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ===== rtl/hbfa_ctrl.sv =====
module hbfa_ctrl #(
    parameter int REGION_COUNT = hbfa_pkg::REGION_COUNT_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    input  hbfa_pkg::req_t                  req,
    output logic                            req_ready,
    output logic                            rsp_valid,
    input  logic                            rsp_ready,
    output logic [hbfa_pkg::ADDR_W-1:0]     rsp_result,
    output logic                            rsp_fault,
    output hbfa_pkg::map_req_t              map_req,
    input  logic [2*hbfa_pkg::WORD_W-1:0]   map_rdata,
    output hbfa_pkg::sum_req_t              sum_req,
    input  logic [hbfa_pkg::WORD_W-1:0]     sum_rdata,
    output hbfa_pkg::status_t               status
);
    import hbfa_pkg::*;

    localparam int MAP_WORDS = REGION_COUNT * 4;
    localparam int MAP_AW = $clog2(MAP_WORDS);
    localparam logic [ADDR_W-1:0] MEM_LIMIT = ADDR_W'(REGION_COUNT) << 20;

    state_t                 state_reg, state_next;
    logic [MAP_AW-1:0]      clr_reg, clr_next;
    logic [MAP_AW:0]        sweep_reg, sweep_next;
    logic [ADDR_W-1:0]      addr_reg, addr_next;
    logic [ADDR_W-1:0]      res_reg, res_next;
    logic                   fault_reg, fault_next;
    logic [WORD_W-1:0]      root_reg [ROOT_WORDS];
    logic [WORD_W-1:0]      root_next [ROOT_WORDS];
    logic [CNT_W-1:0]       free_reg, free_next;
    logic [CNT_W-1:0]       managed_reg, managed_next;
    logic                   ready_reg, ready_next;
    logic [1:0]             ri_reg, ri_next;
    logic [WORD_W-1:0]      roots_reg, roots_next;
    logic [WORD_W-1:0]      regs_reg, regs_next;
    logic [SUM_IDX_W-1:0]   s_reg, s_next;
    logic [REGION_W-1:0]    region_reg, region_next;
    logic [1:0]             j_reg, j_next;
    logic [2:0]             k_reg, k_next;
    logic                   any_reg, any_next;
    logic [WORD_W-1:0]      sumw_reg, sumw_next;
    logic [CNT_W-1:0]       acc_reg, acc_next;

    logic [WORD_W-1:0]      usable_rd, alloc_rd;
    logic [REGION_W-1:0]    min_region;
    logic [SUM_IDX_W-1:0]   first_s;

    assign usable_rd = map_rdata[WORD_W-1:0];
    assign alloc_rd = map_rdata[2*WORD_W-1:WORD_W];
    assign min_region = addr_reg[33:20];
    assign first_s = addr_reg[33:26];

    assign rsp_result = res_reg;
    assign rsp_fault = fault_reg;
    assign status = '{busy: (state_reg == ST_CLEAR), ready: ready_reg,
                      free_count: free_reg, managed_count: managed_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg <= '0;
            free_reg <= '0;
            managed_reg <= '0;
            ready_reg <= 1'b0;
            for (int i = 0; i < ROOT_WORDS; i++)
            begin
                root_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            clr_reg <= clr_next;
            free_reg <= free_next;
            managed_reg <= managed_next;
            ready_reg <= ready_next;
            for (int i = 0; i < ROOT_WORDS; i++)
            begin
                root_reg[i] <= root_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sweep_reg <= sweep_next;
        addr_reg <= addr_next;
        res_reg <= res_next;
        fault_reg <= fault_next;
        ri_reg <= ri_next;
        roots_reg <= roots_next;
        regs_reg <= regs_next;
        s_reg <= s_next;
        region_reg <= region_next;
        j_reg <= j_next;
        k_reg <= k_next;
        any_reg <= any_next;
        sumw_reg <= sumw_next;
        acc_reg <= acc_next;
    end

    always_comb
    begin
        logic [MAP_AW-1:0]      w;
        logic [MAP_ADDR_W-1:0]  w16;
        logic                   any_v;
        logic [WORD_W-1:0]      sumw_v;
        logic [CNT_W-1:0]       acc_v;
        logic [WORD_W-1:0]      bits;
        logic [5:0]             b;
        logic [REGION_W-1:0]    region_v;
        logic [1:0]             j_v;
        logic [WORD_W-1:0]      new_sum;

        state_next = state_reg;
        clr_next = clr_reg;
        sweep_next = sweep_reg;
        addr_next = addr_reg;
        res_next = res_reg;
        fault_next = fault_reg;
        root_next = root_reg;
        free_next = free_reg;
        managed_next = managed_reg;
        ready_next = ready_reg;
        ri_next = ri_reg;
        roots_next = roots_reg;
        regs_next = regs_reg;
        s_next = s_reg;
        region_next = region_reg;
        j_next = j_reg;
        k_next = k_reg;
        any_next = any_reg;
        sumw_next = sumw_reg;
        acc_next = acc_reg;
        map_req = '0;
        sum_req = '0;
        req_ready = 1'b0;
        rsp_valid = 1'b0;
        w = '0;
        w16 = '0;
        any_v = 1'b0;
        sumw_v = '0;
        acc_v = '0;
        bits = '0;
        b = '0;
        region_v = '0;
        j_v = '0;
        new_sum = '0;

        case (state_reg)
            ST_CLEAR:
            begin
                map_req.we = 1'b1;
                map_req.addr = MAP_ADDR_W'(clr_reg);
                if (clr_reg == MAP_AW'(MAP_WORDS - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    addr_next = req.address;
                    res_next = '0;
                    fault_next = 1'b0;
                    state_next = ST_RESP;
                    case (kind_t'(req.kind))
                        K_LOAD:
                        begin
                            if (ready_reg)
                            begin
                                fault_next = 1'b1;
                            end
                            else if ({1'b0, req.word_index} < 17'(MAP_WORDS))
                            begin
                                map_req.we = 1'b1;
                                map_req.addr = req.word_index;
                                map_req.usable = req.word_value;
                            end
                        end
                        K_INIT:
                        begin
                            if (ready_reg || req.address != '0)
                            begin
                                fault_next = 1'b1;
                            end
                            else
                            begin
                                state_next = ST_IN_CHK;
                            end
                        end
                        K_ALLOC:
                        begin
                            if (!ready_reg)
                            begin
                                fault_next = 1'b1;
                            end
                            else if (req.address[11:0] == '0 && req.address < MEM_LIMIT)
                            begin
                                ri_next = req.address[33:32];
                                state_next = ST_AR_LOAD;
                            end
                        end
                        K_FREE:
                        begin
                            if (!ready_reg)
                            begin
                                fault_next = 1'b1;
                            end
                            else if (req.address != '0 && req.address[11:0] == '0
                                     && req.address < MEM_LIMIT)
                            begin
                                map_req.addr = {req.address[33:20], req.address[19:18]};
                                region_next = req.address[33:20];
                                s_next = req.address[33:26];
                                state_next = ST_FR_WAIT;
                            end
                        end
                        K_COUNT:
                        begin
                            if (!ready_reg || req.address != '0)
                            begin
                                fault_next = 1'b1;
                            end
                            else
                            begin
                                res_next = ADDR_W'(free_reg);
                            end
                        end
                        K_HIGH:
                        begin
                            if (!ready_reg || req.address != '0)
                            begin
                                fault_next = 1'b1;
                            end
                            else if ((root_reg[1] | root_reg[2] | root_reg[3]) != '0)
                            begin
                                res_next = ADDR_W'(64'h1_0000_0000);
                            end
                            else
                            begin
                                res_next = ADDR_W'(64'h2000_0000);
                            end
                        end
                        default:
                        begin
                            fault_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_IN_CHK:
            begin
                map_req.addr = '0;
                state_next = ST_IN_SWEEP;
                sweep_next = '0;
                acc_next = '0;
                any_next = 1'b0;
                sumw_next = '0;
            end
            ST_IN_SWEEP:
            begin
                if (sweep_reg < (MAP_AW + 1)'(MAP_WORDS))
                begin
                    map_req.addr = MAP_ADDR_W'(sweep_reg[MAP_AW-1:0]);
                end
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg == '0)
                begin
                    // word 0 comes back first: frame 0 must not be usable
                    if (usable_rd[0])
                    begin
                        fault_next = 1'b1;
                        state_next = ST_RESP;
                    end
                end
                else
                begin
                    w = MAP_AW'(sweep_reg - 1'b1);
                    w16 = MAP_ADDR_W'(w);
                    acc_v = acc_reg + CNT_W'(ones(usable_rd));
                    acc_next = acc_v;
                    any_v = any_reg | (usable_rd != '0);
                    any_next = any_v;
                    sumw_v = sumw_reg;
                    if (w16[1:0] == 2'd3)
                    begin
                        sumw_v[w16[7:2]] = any_v;
                        any_next = 1'b0;
                    end
                    sumw_next = sumw_v;
                    if (w16[7:0] == 8'hFF)
                    begin
                        sum_req.we = 1'b1;
                        sum_req.addr = w16[15:8];
                        sum_req.wdata = sumw_v;
                        root_next[w16[15:14]][w16[13:8]] = (sumw_v != '0);
                        sumw_next = '0;
                    end
                    if (sweep_reg == (MAP_AW + 1)'(MAP_WORDS))
                    begin
                        state_next = ST_RESP;
                        if (acc_v == '0)
                        begin
                            fault_next = 1'b1;
                        end
                        else
                        begin
                            ready_next = 1'b1;
                            free_next = acc_v;
                            managed_next = acc_v;
                            res_next = ADDR_W'(1);
                        end
                    end
                end
            end
            ST_AR_LOAD:
            begin
                roots_next = root_reg[ri_reg]
                    & ((ri_reg == addr_reg[33:32]) ? mask_ge(addr_reg[31:26]) : '1);
                state_next = ST_AR_SCAN;
            end
            ST_AR_SCAN:
            begin
                if (roots_reg == '0)
                begin
                    if (ri_reg == 2'd3)
                    begin
                        state_next = ST_RESP;
                    end
                    else
                    begin
                        ri_next = ri_reg + 1'b1;
                        state_next = ST_AR_LOAD;
                    end
                end
                else
                begin
                    b = low_set(roots_reg);
                    roots_next = roots_reg & (roots_reg - 1'b1);
                    s_next = {ri_reg, b};
                    sum_req.addr = {ri_reg, b};
                    state_next = ST_AS_WAIT;
                end
            end
            ST_AS_WAIT:
            begin
                regs_next = sum_rdata
                    & ((s_reg == first_s) ? mask_ge(addr_reg[25:20]) : '1);
                state_next = ST_AS_SCAN;
            end
            ST_AS_SCAN:
            begin
                if (regs_reg == '0)
                begin
                    state_next = ST_AR_SCAN;
                end
                else
                begin
                    region_v = {s_reg, low_set(regs_reg)};
                    regs_next = regs_reg & (regs_reg - 1'b1);
                    j_v = (region_v == min_region) ? addr_reg[19:18] : 2'd0;
                    region_next = region_v;
                    j_next = j_v;
                    map_req.addr = {region_v, j_v};
                    state_next = ST_AW_WAIT;
                end
            end
            ST_AW_WAIT:
            begin
                bits = usable_rd & ~alloc_rd
                    & ((region_reg == min_region && j_reg == addr_reg[19:18])
                       ? mask_ge(addr_reg[17:12]) : '1);
                if (bits != '0)
                begin
                    b = low_set(bits);
                    map_req.we = 1'b1;
                    map_req.addr = {region_reg, j_reg};
                    map_req.usable = usable_rd;
                    map_req.allocated = alloc_rd | (WORD_W'(1) << b);
                    if (free_reg != '0)
                    begin
                        free_next = free_reg - 1'b1;
                    end
                    res_next = ADDR_W'({region_reg, j_reg, b, 12'h000});
                    k_next = '0;
                    any_next = 1'b0;
                    state_next = ST_RF_RD;
                end
                else if (j_reg == 2'd3)
                begin
                    state_next = ST_AS_SCAN;
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                    map_req.addr = {region_reg, j_reg + 2'd1};
                end
            end
            ST_FR_WAIT:
            begin
                b = addr_reg[17:12];
                if (usable_rd[b] && alloc_rd[b])
                begin
                    map_req.we = 1'b1;
                    map_req.addr = {region_reg, addr_reg[19:18]};
                    map_req.usable = usable_rd;
                    map_req.allocated = alloc_rd & ~(WORD_W'(1) << b);
                    if (free_reg < managed_reg)
                    begin
                        free_next = free_reg + 1'b1;
                    end
                    res_next = ADDR_W'(1);
                    k_next = '0;
                    any_next = 1'b0;
                    state_next = ST_RF_RD;
                end
                else
                begin
                    state_next = ST_RESP;
                end
            end
            ST_RF_RD:
            begin
                if (k_reg < 3'd4)
                begin
                    map_req.addr = {region_reg, k_reg[1:0]};
                end
                if (k_reg != '0)
                begin
                    any_next = any_reg | ((usable_rd & ~alloc_rd) != '0);
                end
                k_next = k_reg + 1'b1;
                if (k_reg == 3'd4)
                begin
                    sum_req.addr = s_reg;
                    state_next = ST_RF_SW;
                end
            end
            ST_RF_SW:
            begin
                new_sum = sum_rdata;
                new_sum[region_reg[5:0]] = any_reg;
                sum_req.we = 1'b1;
                sum_req.addr = s_reg;
                sum_req.wdata = new_sum;
                root_next[s_reg[7:6]][s_reg[5:0]] = (new_sum != '0);
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                rsp_valid = 1'b1;
                if (rsp_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== tb/tb_hierarchical_bitmap_frame_allocator_core.sv =====
`timescale 1ns / 100ps

module tb_hierarchical_bitmap_frame_allocator_core;
    import hbfa_pkg::*;

    localparam int MAP_WORDS = 65536;
    localparam logic [34:0] MEM_TOP = 35'h4_0000_0000;

    typedef struct {
        logic [2:0]  kind;
        logic [34:0] address;
        logic [15:0] word_index;
        logic [63:0] word_value;
        bit          pick_owned;
        bit          hold;
    } op_t;

    typedef struct {
        logic [34:0] result;
        logic        fault;
    } reply_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [119:0] s_axis_tdata;
    logic [2:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [39:0]  m_axis_tdata;
    logic [0:0]   m_axis_tuser;

    hierarchical_bitmap_frame_allocator_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    bit [63:0]   usable_w [MAP_WORDS];
    bit [63:0]   taken_w [MAP_WORDS];
    bit [63:0]   region_sum [256];
    bit [63:0]   root_sum [4];
    bit [22:0]   free_n;
    bit [22:0]   managed_n;
    bit          live;
    logic [34:0] owned [$];

    op_t    pending [$];
    reply_t replies_due [$];
    op_t    cur;
    int     src_gap;
    int     snk_gap;
    int     mismatches;
    bit     calm;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #30ms;
        $display("== FAIL ==");
        $finish;
    end

    function automatic int low_bit(bit [63:0] x);
        int n;
        n = 0;
        while (n < 63 && !x[n]) n++;
        return n;
    endfunction

    function automatic void refresh_region(int region);
        int s;
        bit [63:0] any;
        s = region / 64;
        any = 0;
        for (int j = 0; j < 4; j++) any |= usable_w[region*4+j] & ~taken_w[region*4+j];
        region_sum[s][region%64] = (any != 0);
        root_sum[(s/64)&3][s%64] = (region_sum[s] != 0);
    endfunction

    function automatic logic [34:0] take_frame(logic [34:0] minimum);
        int first, fr, fs, s, region, flo, w, idx;
        bit [63:0] roots, regs, bits;
        if (minimum[11:0] != 0 || minimum >= MEM_TOP) return 0;
        first = int'(minimum >> 12);
        fr = first / 256;
        fs = fr / 64;
        for (int root = fs / 64; root < 4; root++)
        begin
            roots = root_sum[root];
            if (root == fs / 64) roots &= {64{1'b1}} << (fs % 64);
            while (roots != 0)
            begin
                s = root * 64 + low_bit(roots);
                roots &= roots - 1;
                regs = region_sum[s];
                if (s == fs) regs &= {64{1'b1}} << (fr % 64);
                while (regs != 0)
                begin
                    region = s * 64 + low_bit(regs);
                    regs &= regs - 1;
                    flo = (region == fr) ? first % 256 : 0;
                    for (int j = flo / 64; j < 4; j++)
                    begin
                        w = region * 4 + j;
                        bits = usable_w[w] & ~taken_w[w];
                        if (j == flo / 64) bits &= {64{1'b1}} << (flo % 64);
                        if (bits != 0)
                        begin
                            idx = j * 64 + low_bit(bits);
                            taken_w[w][idx%64] = 1'b1;
                            if (free_n != 0) free_n--;
                            refresh_region(region);
                            return ((35'(region) << 8) | 35'(idx)) << 12;
                        end
                    end
                end
            end
        end
        return 0;
    endfunction

    function automatic logic [34:0] release_frame(logic [34:0] frame);
        int region, idx, w;
        if (frame == 0 || frame[11:0] != 0 || frame >= MEM_TOP) return 0;
        region = int'(frame >> 20);
        idx = int'(frame[19:12]);
        w = region * 4 + idx / 64;
        if (!usable_w[w][idx%64] || !taken_w[w][idx%64]) return 0;
        taken_w[w][idx%64] = 1'b0;
        if (free_n < managed_n) free_n++;
        refresh_region(region);
        return 1;
    endfunction

    task automatic predict_beat(op_t op);
        reply_t r;
        int cnt;
        r.result = 0;
        r.fault = 0;
        if (op.kind > K_HIGH) r.fault = 1;
        else if (op.kind == K_LOAD)
        begin
            if (live) r.fault = 1;
            else usable_w[op.word_index] = op.word_value;
        end
        else if (op.kind == K_INIT)
        begin
            cnt = 0;
            if (live || op.address != 0 || usable_w[0][0]) r.fault = 1;
            else
            begin
                for (int w = 0; w < MAP_WORDS; w++) cnt += $countones(usable_w[w]);
                if (cnt == 0) r.fault = 1;
            end
            if (!r.fault)
            begin
                for (int g = 0; g < 16384; g++) refresh_region(g);
                managed_n = 23'(cnt);
                free_n = 23'(cnt);
                live = 1;
                r.result = 1;
            end
        end
        else if (!live) r.fault = 1;
        else if (op.kind == K_ALLOC)
        begin
            r.result = take_frame(op.address);
            if (r.result != 0) owned.push_back(r.result);
        end
        else if (op.kind == K_FREE)
        begin
            r.result = release_frame(op.address);
            if (r.result == 1)
            begin
                for (int i = 0; i < owned.size(); i++)
                begin
                    if (owned[i] == op.address)
                    begin
                        owned.delete(i);
                        break;
                    end
                end
            end
        end
        else if (op.address != 0) r.fault = 1;
        else if (op.kind == K_COUNT) r.result = 35'(free_n);
        else r.result = (root_sum[1] | root_sum[2] | root_sum[3]) != 0 ?
                        35'h1_0000_0000 : 35'h0_2000_0000;
        replies_due.push_back(r);
    endtask

    function automatic void add_op(logic [2:0] k, logic [34:0] a, logic [15:0] wi = 0,
                                   logic [63:0] wv = 0, bit po = 0, bit h = 0);
        op_t op;
        op.kind = k;
        op.address = a;
        op.word_index = wi;
        op.word_value = wv;
        op.pick_owned = po;
        op.hold = h;
        pending.push_back(op);
    endfunction

    function automatic logic [63:0] rand_word();
        logic [63:0] v;
        v = {$urandom(), $urandom()};
        case ($urandom_range(0, 3))
            0: v = {64{1'b1}};
            1: v = v & {$urandom(), $urandom()};
            default: ;
        endcase
        return v;
    endfunction

    function automatic logic [34:0] rand_min();
        logic [34:0] a;
        case ($urandom_range(0, 3))
            0: a = 0;
            1: a = 35'($urandom_range(0, 1023)) << 12;
            2: a = (owned.size() > 0) ? owned[$urandom_range(0, owned.size()-1)] :
                   35'($urandom_range(0, 65535)) << 12;
            default: a = {1'b0, 22'($urandom()), 12'h0};
        endcase
        return a & ~35'hFFF;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= '0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready) predict_beat(cur);
            calm = pending.size() < 120;
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (src_gap > 0)
                begin
                    src_gap--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (pending.size() > 0 && !(pending[0].hold && replies_due.size() > 0))
                begin
                    if (!calm && $urandom_range(0, 9) == 0)
                    begin
                        src_gap = $urandom_range(0, 17);
                        s_axis_tvalid <= 1'b0;
                    end
                    else
                    begin
                        cur = pending.pop_front();
                        if (cur.pick_owned && owned.size() > 0)
                            cur.address = owned[$urandom_range(0, owned.size()-1)];
                        s_axis_tvalid <= 1'b1;
                        s_axis_tdata  <= {5'b0, cur.word_value, cur.word_index, cur.address};
                        s_axis_tuser  <= cur.kind;
                    end
                end
                else s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        reply_t e;
        if (!rst_n) m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (replies_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected beat: result=%h fault=%b",
                                 m_axis_tdata[34:0], m_axis_tuser);
                end
                else
                begin
                    e = replies_due.pop_front();
                    if (m_axis_tdata[34:0] !== e.result || m_axis_tuser[0] !== e.fault)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp result=%h fault=%b, got result=%h fault=%b",
                                     e.result, e.fault, m_axis_tdata[34:0], m_axis_tuser);
                    end
                end
            end
            if (snk_gap > 0)
            begin
                snk_gap--;
                m_axis_tready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                snk_gap = $urandom_range(0, 17);
                m_axis_tready <= 1'b0;
            end
            else m_axis_tready <= 1'b1;
        end
    end

    initial
    begin
        int pick;
        logic [15:0] wi;
        rst_n = 1'b0;
        mismatches = 0;
        src_gap = 0;
        snk_gap = 0;
        calm = 0;
        live = 0;
        free_n = 0;
        managed_n = 0;

        // before init: every operation but load faults
        add_op(K_COUNT, 0);
        add_op(K_ALLOC, 0);
        add_op(K_FREE, 35'h1000);
        add_op(K_HIGH, 0);
        add_op(3'd6, 0);
        add_op(3'd7, {35{1'b1}}, 16'hFFFF, {64{1'b1}});
        add_op(K_INIT, 0);
        add_op(K_LOAD, 0, 16'd0, {64{1'b1}});
        add_op(K_INIT, 0);
        add_op(K_LOAD, {35{1'b1}}, 16'd0, {{63{1'b1}}, 1'b0});
        add_op(K_LOAD, 0, 16'hFFFF, {64{1'b1}});
        add_op(K_LOAD, 0, 16'd16384, 64'h8000_0000_0000_0001);
        add_op(K_INIT, 35'h1);
        for (int i = 0; i < 40; i++)
        begin
            pick = $urandom_range(0, 2);
            wi = (pick == 0) ? 16'($urandom_range(1, 63)) :
                 (pick == 1) ? 16'($urandom_range(16384, 65535)) : 16'($urandom());
            if (wi == 0) wi = 1;
            add_op(K_LOAD, 35'($urandom()), wi, rand_word());
        end
        add_op(K_INIT, 0);
        add_op(K_INIT, 0);
        add_op(K_LOAD, 0, 16'd1, 64'h1);
        add_op(K_COUNT, 0);
        add_op(K_COUNT, 35'h400000000);
        add_op(K_HIGH, 35'h1);
        add_op(K_HIGH, 0);
        add_op(K_ALLOC, 0);
        add_op(K_ALLOC, 35'h1001);
        add_op(K_ALLOC, MEM_TOP);
        add_op(K_ALLOC, {35{1'b1}});
        add_op(K_ALLOC, MEM_TOP - 35'h1000);
        add_op(K_FREE, 0);
        add_op(K_FREE, 35'h2004);
        add_op(K_FREE, MEM_TOP);
        add_op(K_FREE, 35'h3000);
        add_op(K_FREE, 0, 0, 0, 1);

        for (int i = 0; i < 880; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
            begin
                case ($urandom_range(0, 9))
                    0: add_op(K_ALLOC, 35'({$urandom_range(0, 7), $urandom()}));
                    1: add_op(K_ALLOC, MEM_TOP | (35'($urandom()) & ~35'hFFF));
                    default: add_op(K_ALLOC, rand_min());
                endcase
            end
            else if (pick < 75)
            begin
                if ($urandom_range(0, 9) < 7) add_op(K_FREE, 0, 0, 0, 1);
                else if ($urandom_range(0, 1)) add_op(K_FREE, 35'({$urandom_range(0, 7),
                                                                      $urandom()}));
                else add_op(K_FREE, rand_min());
            end
            else if (pick < 85) add_op(K_COUNT, ($urandom_range(0, 7) == 0) ?
                                       35'({$urandom_range(0, 7), $urandom()}) : 35'd0);
            else if (pick < 93) add_op(K_HIGH, ($urandom_range(0, 7) == 0) ?
                                       35'({$urandom_range(0, 7), $urandom()}) : 35'd0);
            else if (pick < 97) add_op(3'($urandom_range(6, 7)), 35'($urandom()));
            else add_op(K_LOAD, 0, 16'($urandom()), rand_word());
            if (i % 300 == 150) add_op(K_COUNT, 0, 0, 0, 0, 1);
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        wait (pending.size() == 0 && !s_axis_tvalid && replies_due.size() == 0);
        repeat (100) @(posedge clk);
        if (mismatches == 0 && replies_due.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/hbfa_pkg.sv
rtl/hbfa_ram.sv
rtl/hbfa_ctrl.sv
rtl/hierarchical_bitmap_frame_allocator_core.sv
tb/tb_hierarchical_bitmap_frame_allocator_core.sv
